// ----- hdl/cosine_taylor_fixed_point_unit_defines.svh -----
// assertion macros shared by the cosine unit
`ifndef COSINE_TAYLOR_FIXED_POINT_UNIT_DEFINES_SVH
`define COSINE_TAYLOR_FIXED_POINT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ctfp assertion failed");
`define CTFP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("ctfp assertion failed");
`else
`define CTFP_ASSERT(lbl, prop)
`define CTFP_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- hdl/ctfp_pkg.sv -----
// constants, command and status types of the cosine unit
package ctfp_pkg;

  localparam int TERMS = 10;

  localparam int ANGLE_W = 32;
  localparam int COS_W   = 32;

  localparam int RED_W     = 60;
  localparam int RED_STEPS = 13;
  localparam int RAD_SHIFT = 28;
  localparam int Q_SHIFT   = 14;
  localparam int FRAC_W    = 30;

  localparam int X_W   = 34;
  localparam int P_W   = 36;
  localparam int SUM_W = 37;
  localparam int MA_W  = 40;
  localparam int MB_H  = X_W / 2;

  localparam int DIV_CYC = P_W / 2;
  localparam int CNT_W   = $clog2((RED_STEPS > DIV_CYC) ? RED_STEPS : DIV_CYC);
  localparam int K_W     = $clog2(TERMS);
  localparam int DIV_W   = $clog2((2 * TERMS - 3) * (2 * TERMS - 2) + 1);

  localparam logic [RED_W-1:0] PI_Q44     = RED_W'(64'h3243_F6A8_885A);
  localparam logic [RED_W-1:0] TWO_PI_Q44 = RED_W'(64'h6487_ED51_10B4);
  localparam logic [RED_W-1:0] DEG_360    = RED_W'(360 * 65536);
  localparam logic [RED_W-1:0] DEG_180    = RED_W'(180 * 65536);
  localparam logic [RED_W-1:0] DEG_90     = RED_W'(90 * 65536);
  localparam logic [MA_W-1:0]  DEG_TO_RAD = MA_W'(PI_Q44 / 180);

  localparam logic [X_W-1:0]          ONE_X       = X_W'(2 ** FRAC_W);
  localparam logic signed [SUM_W-1:0] ONE_SUM     = SUM_W'(2 ** FRAC_W);
  localparam logic signed [SUM_W-1:0] NEG_ONE_SUM = -ONE_SUM;
  localparam logic signed [COS_W-1:0] ONE_COS     = COS_W'(2 ** FRAC_W);
  localparam logic signed [COS_W-1:0] NEG_ONE_COS = -ONE_COS;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REDUCE,
    OP_FOLD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_DIV,
    OP_ACC,
    OP_OUT
  } ctfp_op_e;

  typedef enum logic [1:0] {
    MSEL_CONV,
    MSEL_SQR,
    MSEL_TERM
  } ctfp_msel_e;

  typedef struct packed {
    ctfp_op_e         op;
    ctfp_msel_e       msel;
    logic [K_W-1:0]   k;
  } ctfp_cmd_t;

  typedef struct packed {
    logic deg;
    logic hit90;
  } ctfp_status_t;

endpackage

// ----- hdl/ctfp_if.sv -----
// angle and cosine stream interfaces
interface ctfp_angle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface ctfp_cosine_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cosine;

  modport source (output valid, output cosine, input ready);
  modport sink   (input valid, input cosine, output ready);
endinterface

// ----- hdl/ctfp_ctrl.sv -----
// sequencer of the cosine unit: handshakes and datapath commands
`include "cosine_taylor_fixed_point_unit_defines.svh"

module ctfp_ctrl import ctfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  ctfp_status_t status_i,
  output ctfp_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_REDUCE = 8'b0000_0010,
    ST_FOLD   = 8'b0000_0100,
    ST_MUL_LO = 8'b0000_1000,
    ST_MUL_HI = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_ACC    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } ctfp_state_e;

  ctfp_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [K_W-1:0]   k_q, k_d;
  ctfp_msel_e       msel_q, msel_d;
  logic             out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    msel_d      = msel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.msel  = msel_q;
    cmd_o.k     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cnt_d    = '0;
          state_d  = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.op = OP_REDUCE;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RED_STEPS - 1)) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.op = OP_FOLD;
        if (status_i.deg && status_i.hit90) begin
          state_d = ST_DONE;
        end else if (status_i.deg) begin
          msel_d  = MSEL_CONV;
          state_d = ST_MUL_LO;
        end else begin
          msel_d  = MSEL_SQR;
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.op = OP_MUL_HI;
        unique case (msel_q)
          MSEL_CONV: begin
            msel_d  = MSEL_SQR;
            state_d = ST_MUL_LO;
          end
          MSEL_SQR: begin
            msel_d  = MSEL_TERM;
            k_d     = K_W'(1);
            state_d = ST_MUL_LO;
          end
          default: begin
            cnt_d   = '0;
            state_d = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        if (k_q == K_W'(TERMS - 1)) begin
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_MUL_LO;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      msel_q      <= MSEL_CONV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      msel_q      <= msel_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CTFP_ASSERT_NEVER(a_k_range, k_q > K_W'(TERMS - 1))
  `CTFP_ASSERT(a_div_len, state_q == ST_ACC |-> $past(state_q) == ST_DIV && $past(cnt_q) == CNT_W'(DIV_CYC - 1))
  `CTFP_ASSERT(a_accept_start, in_valid_i && in_ready_o |=> state_q == ST_REDUCE)
  `CTFP_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q) == ST_DONE)

endmodule

// ----- hdl/ctfp_datapath.sv -----
// reduction, shared multiplier, term divider and accumulator
module ctfp_datapath import ctfp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  input  ctfp_cmd_t                 cmd_i,
  output ctfp_status_t              status_o,
  output logic signed [COS_W-1:0]   cosine_o
);

  logic                      unit_q;
  logic                      deg_q, deg_d;
  logic                      zero_q, zero_d;
  logic [RED_W-1:0]          rem_q, rem_d;
  logic [RED_W-1:0]          dsor_q, dsor_d;
  logic [X_W-1:0]            x_q, x_d;
  logic [X_W-1:0]            t_q, t_d;
  logic [MA_W+MB_H-1:0]      plo_q, plo_d;
  logic [DIV_W-1:0]          dr_q, dr_d;
  logic [P_W-1:0]            dq_q, dq_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic signed [COS_W-1:0]   cos_q, cos_d;

  logic [ANGLE_W:0]          ext;
  logic [ANGLE_W:0]          mag;
  logic                      hit90;
  logic [RED_W-1:0]          deg_fold;
  logic [RED_W-1:0]          rad_fold;
  logic [MA_W-1:0]           ma;
  logic [X_W-1:0]            mb;
  logic [MB_H-1:0]           mb_half;
  logic [MA_W+MB_H-1:0]      pp;
  logic [MA_W+X_W-1:0]       full;
  logic [P_W-1:0]            mres;
  logic [K_W:0]              two_k;
  logic [2*K_W+1:0]          dv_full;
  logic [DIV_W-1:0]          dv;
  logic [DIV_W-1:0]          dr_nxt;
  logic [P_W-1:0]            dq_nxt;
  logic signed [COS_W-1:0]   sat;

  assign ext      = {angle_i[ANGLE_W-1], angle_i};
  assign mag      = ext[ANGLE_W] ? (~ext + 1'b1) : ext;
  assign hit90    = deg_q && (rem_q == DEG_90);
  assign deg_fold = (rem_q > DEG_180) ? (DEG_360 - rem_q) : rem_q;
  assign rad_fold = (rem_q > PI_Q44) ? (TWO_PI_Q44 - rem_q) : rem_q;

  assign status_o.deg   = deg_q;
  assign status_o.hit90 = hit90;
  assign cosine_o       = cos_q;

  // shared multiplier, one half of b per beat
  always_comb begin
    unique case (cmd_i.msel)
      MSEL_CONV: begin
        ma = DEG_TO_RAD;
        mb = t_q;
      end
      MSEL_SQR: begin
        ma = MA_W'(x_q);
        mb = x_q;
      end
      default: begin
        ma = MA_W'(t_q);
        mb = x_q;
      end
    endcase
  end

  assign mb_half = (cmd_i.op == OP_MUL_LO) ? mb[MB_H-1:0] : mb[X_W-1:MB_H];
  assign pp      = ma * mb_half;
  assign full    = {pp, MB_H'(0)} + (MA_W+X_W)'(plo_q);
  assign mres    = full[FRAC_W +: P_W];

  // divisor (2k-1)*2k
  assign two_k   = {cmd_i.k, 1'b0};
  assign dv_full = (2*K_W+2)'(two_k - 1'b1) * (2*K_W+2)'(two_k);
  assign dv      = DIV_W'(dv_full);

  // restoring division, two quotient bits per beat
  always_comb begin
    logic [DIV_W:0] trial;
    logic [DIV_W-1:0] r;
    logic [P_W-1:0] q;
    r = dr_q;
    q = dq_q;
    for (int i = 0; i < 2; i++) begin
      trial = {r, q[P_W-1]};
      q     = {q[P_W-2:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        r    = DIV_W'(trial - {1'b0, dv});
        q[0] = 1'b1;
      end else begin
        r = DIV_W'(trial);
      end
    end
    dr_nxt = r;
    dq_nxt = q;
  end

  always_comb begin
    priority if (sum_q > ONE_SUM) begin
      sat = ONE_COS;
    end else if (sum_q < NEG_ONE_SUM) begin
      sat = NEG_ONE_COS;
    end else begin
      sat = COS_W'(sum_q);
    end
  end

  always_comb begin
    deg_d  = deg_q;
    zero_d = zero_q;
    rem_d  = rem_q;
    dsor_d = dsor_q;
    x_d    = x_q;
    t_d    = t_q;
    plo_d  = plo_q;
    dr_d   = dr_q;
    dq_d   = dq_q;
    sum_d  = sum_q;
    cos_d  = cos_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        deg_d  = unit_q;
        zero_d = 1'b0;
        if (unit_q) begin
          rem_d  = RED_W'(mag);
          dsor_d = DEG_360 << (RED_STEPS - 1);
        end else begin
          rem_d  = RED_W'(mag) << RAD_SHIFT;
          dsor_d = TWO_PI_Q44 << (RED_STEPS - 1);
        end
      end
      OP_REDUCE: begin
        if (rem_q >= dsor_q) begin
          rem_d = rem_q - dsor_q;
        end
        dsor_d = dsor_q >> 1;
      end
      OP_FOLD: begin
        sum_d = ONE_SUM;
        if (deg_q) begin
          zero_d = hit90;
          t_d    = X_W'(deg_fold);
        end else begin
          x_d = X_W'(rad_fold >> Q_SHIFT);
        end
      end
      OP_MUL_LO: begin
        plo_d = pp;
      end
      OP_MUL_HI: begin
        unique case (cmd_i.msel)
          MSEL_CONV: begin
            x_d = X_W'(mres);
          end
          MSEL_SQR: begin
            x_d = X_W'(mres);
            t_d = ONE_X;
          end
          default: begin
            dq_d = mres;
            dr_d = '0;
          end
        endcase
      end
      OP_DIV: begin
        dr_d = dr_nxt;
        dq_d = dq_nxt;
      end
      OP_ACC: begin
        t_d = X_W'(dq_q);
        if (cmd_i.k[0]) begin
          sum_d = sum_q - $signed(SUM_W'(dq_q));
        end else begin
          sum_d = sum_q + $signed(SUM_W'(dq_q));
        end
      end
      OP_OUT: begin
        cos_d = zero_q ? '0 : sat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= 1'b0;
    end else if (cfg_we_i) begin
      unit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q  <= deg_d;
    zero_q <= zero_d;
    rem_q  <= rem_d;
    dsor_q <= dsor_d;
    x_q    <= x_d;
    t_q    <= t_d;
    plo_q  <= plo_d;
    dr_q   <= dr_d;
    dq_q   <= dq_d;
    sum_q  <= sum_d;
    cos_q  <= cos_d;
  end

endmodule

// ----- hdl/cosine_taylor_fixed_point_unit.sv -----
// Cosine of a signed Q16.16 angle (radians, or degrees when the unit bit is set) as signed
// Q2.30 saturated to plus or minus one, summed over TERMS Taylor terms. One angle is worked
// at a time: restoring range reduction, then squaring of the angle, and per term a multiply
// in low and high halves, a two-bit-per-cycle restoring divider and an accumulate. A degree
// angle is first converted to radians by a further multiply, and a degree angle that reduces
// to exactly ninety skips the series and gives zero. Most of the time per term goes to the
// term divider. A finished result waits in the output register while the next angle is
// already taken.
module cosine_taylor_fixed_point_unit import ctfp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  ctfp_angle_if.sink     angle_i,
  ctfp_cosine_if.source  cosine_o
);

  ctfp_cmd_t    cmd;
  ctfp_status_t status;

  ctfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (angle_i.valid),
    .in_ready_o  (angle_i.ready),
    .out_valid_o (cosine_o.valid),
    .out_ready_i (cosine_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ctfp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .angle_i     (angle_i.angle),
    .cmd_i       (cmd),
    .status_o    (status),
    .cosine_o    (cosine_o.cosine)
  );

endmodule
